/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rotenc_pkg.sv */
`timescale 1ns / 1ps

package rotenc_pkg;

  // tick counter width, any value from 8 to 32
  localparam int TickCntW = 16;
  // width used to compare counters against the 16-bit intervals
  localparam int CmpW = (TickCntW > 16) ? TickCntW : 16;

  localparam int PosW  = 8;
  localparam int IntvW = 16;
  localparam int StepW = 4;
  // signed sum of position and step, covers -15 .. 270
  localparam int SumW  = PosW + 2;

  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_POS_MIN    = 3'd0,
    REG_POS_MAX    = 3'd1,
    REG_FASTEST_IV = 3'd2,
    REG_FASTER_IV  = 3'd3,
    REG_FASTEST_ST = 3'd4,
    REG_FASTER_ST  = 3'd5,
    REG_CLICK_IV   = 3'd6,
    REG_HAS_BUTTON = 3'd7
  } reg_idx_t;

  localparam logic [PosW-1:0]  PosMinRst    = 8'd0;
  localparam logic [PosW-1:0]  PosMaxRst    = 8'd255;
  localparam logic [IntvW-1:0] FastestIvRst = 16'd50;
  localparam logic [IntvW-1:0] FasterIvRst  = 16'd100;
  localparam logic [StepW-1:0] FastestStRst = 4'd5;
  localparam logic [StepW-1:0] FasterStRst  = 4'd2;
  localparam logic [IntvW-1:0] ClickIvRst   = 16'd200;
  localparam logic [PosW-1:0]  PosRst       = 8'd127;

endpackage

/* rtl/rotary_encoder_accel_position.sv */
`timescale 1ns / 1ps
// Quadrature encoder with rotation acceleration and a debounced button. Each
// input word is either one sample of lines A, B and the button (tuser = 0) or
// a load of a new shaft position (tuser = 1); each gives exactly one result
// word with the position, a turned flag and a clicked flag. A rising edge of
// A steps the position by +1 (B high) or -1 (B low), scaled by fastest_step or
// faster_step when fewer ticks than the matching interval passed since the
// last turn; the position is then clamped to [pos_min, pos_max] on every
// sample. With has_button set, a low button line reports a click once more
// than click_interval ticks passed since the last click. Throughput is one
// word per clock while out_tready keeps up: the whole update is one
// combinational pass from the state registers to the result register, and a
// two-entry output (result register plus skid) keeps in_tready high while one
// result waits. Registers sit at byte address 4*i on the apb-style port.

module rotary_encoder_accel_position (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,  // line_a, line_b, button_level, new_position[7:0], zero pad
  input  logic [0:0]                         in_tuser,  // op
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata, // position[7:0], turned, clicked, zero pad
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rotenc_pkg::CfgAddrW-1:0]    cfg_paddr,
  input  logic [rotenc_pkg::CfgDataW-1:0]    cfg_pwdata,
  output logic [rotenc_pkg::CfgDataW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import rotenc_pkg::*;
  `include "assert_macros.svh"

  // configuration registers
  logic [PosW-1:0]  pos_min_r, pos_max_r;
  logic [IntvW-1:0] fastest_iv_r, faster_iv_r, click_iv_r;
  logic [StepW-1:0] fastest_st_r, faster_st_r;
  logic             has_button_r;

  // encoder state
  logic                prev_a_r;
  logic [PosW-1:0]     pos_r;
  logic [TickCntW-1:0] ticks_turn_r, ticks_click_r;

  // output register and skid stage
  logic            out_valid_r, skid_valid_r;
  logic [PosW+1:0] out_data_r, skid_data_r;

  // unpacked input word
  logic            acc;
  op_t             op;
  logic            line_a, line_b, button_level;
  logic [PosW-1:0] new_position;

  // datapath
  logic [TickCntW-1:0]    tst, tsc;
  logic                   rise, click_hit;
  logic [StepW-1:0]       mag;
  logic signed [SumW-1:0] delta_s, sum_s;
  logic [PosW-1:0]        pos_nxt;
  logic                   turned;
  logic [PosW+1:0]        res;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign acc          = in_tvalid && in_tready;
  assign op           = op_t'(in_tuser[0]);
  assign line_a       = in_tdata[0];
  assign line_b       = in_tdata[1];
  assign button_level = in_tdata[2];
  assign new_position = in_tdata[10:3];

  // saturating advance of both tick counters
  assign tst = (&ticks_turn_r)  ? ticks_turn_r  : ticks_turn_r  + 1'b1;
  assign tsc = (&ticks_click_r) ? ticks_click_r : ticks_click_r + 1'b1;

  assign rise = line_a && !prev_a_r;

  // step size picked from the time since the last turn
  always_comb begin
    if (CmpW'(tst) < CmpW'(fastest_iv_r)) begin
      mag = fastest_st_r;
    end else if (CmpW'(tst) < CmpW'(faster_iv_r)) begin
      mag = faster_st_r;
    end else begin
      mag = StepW'(1);
    end
  end

  always_comb begin
    delta_s = '0;
    if (rise) begin
      delta_s = line_b ? signed'(SumW'(mag)) : -signed'(SumW'(mag));
    end
    sum_s = signed'(SumW'(pos_r)) + delta_s;
    // lower limit wins when the limits cross
    if (sum_s < signed'(SumW'(pos_min_r))) begin
      pos_nxt = pos_min_r;
    end else if (sum_s > signed'(SumW'(pos_max_r))) begin
      pos_nxt = pos_max_r;
    end else begin
      pos_nxt = sum_s[PosW-1:0];
    end
  end

  assign turned    = rise && (mag != '0);
  assign click_hit = has_button_r && !button_level && (CmpW'(tsc) > CmpW'(click_iv_r));

  always_comb begin
    if (op == OP_LOAD) begin
      res = {1'b0, 1'b0, new_position};
    end else begin
      res = {click_hit, turned, pos_nxt};
    end
  end

  // encoder state update, one word per clock while in_tready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r      <= 1'b1;
      pos_r         <= PosRst;
      ticks_turn_r  <= '0;
      ticks_click_r <= '0;
    end else if (acc) begin
      if (op == OP_LOAD) begin
        pos_r <= new_position;
      end else begin
        pos_r         <= pos_nxt;
        prev_a_r      <= line_a;
        ticks_turn_r  <= rise ? '0 : tst;
        ticks_click_r <= click_hit ? '0 : tsc;
      end
    end
  end

  // result register with skid stage behind it
  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= acc;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (!out_valid_r) begin
      out_data_r <= res;
    end
    if (acc && out_valid_r && !out_tready) begin
      skid_data_r <= res;
    end
  end

  // configuration port, word index from paddr[4:2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r    <= PosMinRst;
      pos_max_r    <= PosMaxRst;
      fastest_iv_r <= FastestIvRst;
      faster_iv_r  <= FasterIvRst;
      fastest_st_r <= FastestStRst;
      faster_st_r  <= FasterStRst;
      click_iv_r   <= ClickIvRst;
      has_button_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POS_MIN:    pos_min_r    <= cfg_pwdata[PosW-1:0];
        REG_POS_MAX:    pos_max_r    <= cfg_pwdata[PosW-1:0];
        REG_FASTEST_IV: fastest_iv_r <= cfg_pwdata[IntvW-1:0];
        REG_FASTER_IV:  faster_iv_r  <= cfg_pwdata[IntvW-1:0];
        REG_FASTEST_ST: fastest_st_r <= cfg_pwdata[StepW-1:0];
        REG_FASTER_ST:  faster_st_r  <= cfg_pwdata[StepW-1:0];
        REG_CLICK_IV:   click_iv_r   <= cfg_pwdata[IntvW-1:0];
        REG_HAS_BUTTON: has_button_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POS_MIN:    cfg_prdata = CfgDataW'(pos_min_r);
      REG_POS_MAX:    cfg_prdata = CfgDataW'(pos_max_r);
      REG_FASTEST_IV: cfg_prdata = CfgDataW'(fastest_iv_r);
      REG_FASTER_IV:  cfg_prdata = CfgDataW'(faster_iv_r);
      REG_FASTEST_ST: cfg_prdata = CfgDataW'(fastest_st_r);
      REG_FASTER_ST:  cfg_prdata = CfgDataW'(faster_st_r);
      REG_CLICK_IV:   cfg_prdata = CfgDataW'(click_iv_r);
      REG_HAS_BUTTON: cfg_prdata = CfgDataW'(has_button_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // skid holds a word only behind a full result register
  `ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full with empty output")
  // a rising edge of A restarts the turn interval
  `ASSERT_IMPL(a_turn_clears, acc && (op == OP_TICK) && rise, ticks_turn_r == '0, "turn counter not cleared")
  // a load leaves counters and edge history alone
  `ASSERT_IMPL(a_load_keeps, acc && (op == OP_LOAD), $stable(ticks_turn_r) && $stable(ticks_click_r) && $stable(prev_a_r), "load disturbed tick state")

endmodule

/* tb/sv/tb_rotary_encoder_accel_position.sv */
`timescale 1ns / 1ps

module tb_rotary_encoder_accel_position;
  import rotenc_pkg::*;

  // saturation value of the tick counters
  localparam longint unsigned TickMax = (64'd1 << TickCntW) - 64'd1;
  // cycles with nothing accepted on any port before the run is given up
  localparam int IdleLimit = 4000;

  // one expected result word
  typedef struct {
    logic [PosW-1:0] position;
    logic            turned;
    logic            clicked;
  } enc_result_t;

  // tracks shaft position, tick ages and settings; queues expected words
  class encoder_scoreboard;
    logic [PosW-1:0]  lo_lim, hi_lim;
    logic [IntvW-1:0] fastest_iv, faster_iv, click_iv;
    logic [StepW-1:0] fastest_mul, faster_mul;
    bit               button_on;
    bit               last_a;
    logic [PosW-1:0]  shaft;
    longint unsigned  turn_age, click_age;
    enc_result_t      expected_q[$];
    int               mismatches;
    int               checked;

    function new();
      lo_lim      = PosMinRst;
      hi_lim      = PosMaxRst;
      fastest_iv  = FastestIvRst;
      faster_iv   = FasterIvRst;
      fastest_mul = FastestStRst;
      faster_mul  = FasterStRst;
      click_iv    = ClickIvRst;
      button_on   = 1'b1;
      last_a      = 1'b1;
      shaft       = PosRst;
      turn_age    = 0;
      click_age   = 0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // register write, masked to the register width
    function void write_reg(reg_idx_t idx, logic [CfgDataW-1:0] v);
      case (idx)
        REG_POS_MIN:    lo_lim      = v[PosW-1:0];
        REG_POS_MAX:    hi_lim      = v[PosW-1:0];
        REG_FASTEST_IV: fastest_iv  = v[IntvW-1:0];
        REG_FASTER_IV:  faster_iv   = v[IntvW-1:0];
        REG_FASTEST_ST: fastest_mul = v[StepW-1:0];
        REG_FASTER_ST:  faster_mul  = v[StepW-1:0];
        REG_CLICK_IV:   click_iv    = v[IntvW-1:0];
        REG_HAS_BUTTON: button_on   = v[0];
        default: ;
      endcase
    endfunction

    // accepted input word: advance the encoder state, queue its result
    function void note_word(op_t op, bit a, bit b, bit btn, logic [PosW-1:0] newpos);
      enc_result_t r;
      int step;
      int sum;
      step = 0;
      r.turned  = 1'b0;
      r.clicked = 1'b0;
      if (op == OP_LOAD) begin
        // load is unclamped and leaves counters and last A alone
        shaft = newpos;
        r.position = shaft;
        expected_q.push_back(r);
        return;
      end
      if (turn_age < TickMax) turn_age++;
      if (click_age < TickMax) click_age++;
      if (a && !last_a) begin
        step = b ? 1 : -1;
        if (turn_age < fastest_iv) step = step * int'(fastest_mul);
        else if (turn_age < faster_iv) step = step * int'(faster_mul);
        turn_age = 0;
      end
      // lower limit wins when the limits are crossed
      sum = int'(shaft) + step;
      if (sum < int'(lo_lim)) sum = int'(lo_lim);
      else if (sum > int'(hi_lim)) sum = int'(hi_lim);
      shaft  = sum[PosW-1:0];
      last_a = a;
      if (button_on && !btn && click_age > click_iv) begin
        r.clicked = 1'b1;
        click_age = 0;
      end
      r.position = shaft;
      r.turned   = (step != 0);
      expected_q.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // accepted result word against the oldest expectation
    function void check_result(logic [15:0] word);
      enc_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("word %0d (%h) arrived with nothing expected", checked, word));
        return;
      end
      want = expected_q.pop_front();
      if (word[7:0] !== want.position)
        note_mismatch($sformatf("word %0d position: expected %0d, got %0d",
                                checked, want.position, word[7:0]));
      if (word[8] !== want.turned)
        note_mismatch($sformatf("word %0d turned: expected %0b, got %0b",
                                checked, want.turned, word[8]));
      if (word[9] !== want.clicked)
        note_mismatch($sformatf("word %0d clicked: expected %0b, got %0b",
                                checked, want.clicked, word[9]));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;
  logic [0:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  encoder_scoreboard board;

  // gap control: no_gaps forces both sides to full rate, send_quiet only the sender
  bit no_gaps    = 1'b0;
  bit send_quiet = 1'b0;

  // quadrature generator state: gray index, direction, ticks left at this index
  int quad_idx    = 0;
  int quad_dir    = 1;
  int dwell_left  = 0;
  int btn_left    = 0;
  bit btn_now     = 1'b1;

  rotary_encoder_accel_position uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet || no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // ticks held at one gray index; rising edges of A are four indexes apart,
  // so the spread lands turns on both sides of the usual intervals
  function automatic int pick_dwell();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 2);
    if (r < 7) return $urandom_range(3, 30);
    if (r < 9) return $urandom_range(31, 60);
    return $urandom_range(61, 150);
  endfunction

  // offer one word and hold it until accepted; in_tvalid stays high afterwards,
  // so whatever follows must drive it in the same step
  task automatic send_word(op_t op, bit a, bit b, bit btn, logic [PosW-1:0] newpos);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, newpos, btn, b, a};
    do @(posedge clk); while (!in_tready);
    board.note_word(op, a, b, btn, newpos);
  endtask

  // stop offering and wait until every result is back, plus the block's latency
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // setup cycle, access cycle, then idle on the bus; bits above the
  // register width carry junk that the block must drop
  task automatic write_reg(reg_idx_t idx, int unsigned value, int width);
    logic [CfgDataW-1:0] wd;
    wd = CfgDataW'(value);
    if (width < CfgDataW) wd = wd | (CfgDataW'($urandom) << width);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wd;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_reg(idx, wd);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int pmin, int pmax, int fiv, int rfiv, int fst, int rst,
                                int civ, int btn);
    write_reg(REG_POS_MIN,    pmin, PosW);
    write_reg(REG_POS_MAX,    pmax, PosW);
    write_reg(REG_FASTEST_IV, fiv,  IntvW);
    write_reg(REG_FASTER_IV,  rfiv, IntvW);
    write_reg(REG_FASTEST_ST, fst,  StepW);
    write_reg(REG_FASTER_ST,  rst,  StepW);
    write_reg(REG_CLICK_IV,   civ,  IntvW);
    write_reg(REG_HAS_BUTTON, btn,  1);
  endtask

  // one setting per phase: extremes in phases 1 to 4 and 8, random ones otherwise
  task automatic pick_settings(int ph);
    case (ph)
      // zero intervals: never accelerated, every press clicks
      1: apply_settings(0, 255, 0, 0, 15, 15, 0, 1);
      // narrow window with big fastest step
      2: apply_settings(100, 140, 8, 30, 15, 3, 10, 1);
      // crossed limits, zero fastest step, no button
      3: apply_settings(200, 50, 20, 40, 0, 1, 65535, 0);
      // pinned position, every turn counts as fastest
      4: apply_settings(255, 255, 65535, 65535, 1, 15, 5, 1);
      // zero faster step
      8: apply_settings(0, 255, 30, 90, 5, 0, 60, 1);
      default: begin
        apply_settings($urandom_range(0, 120), $urandom_range(90, 255),
                       $urandom_range(0, 60), $urandom_range(0, 150),
                       $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 300), ($urandom_range(0, 4) != 0));
      end
    endcase
  endtask

  // mostly clean quadrature with a bouncing button, some loads and noise
  task automatic random_word();
    int r;
    bit a, b;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_word(OP_LOAD, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                            : 8'($urandom));
    end else if (r < 13) begin
      send_word(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                8'($urandom));
    end else begin
      if (dwell_left == 0) begin
        if ($urandom_range(0, 9) == 0) quad_dir = -quad_dir;
        quad_idx   = (quad_idx + quad_dir) & 3;
        dwell_left = pick_dwell();
      end else begin
        dwell_left--;
      end
      if (btn_left == 0) begin
        btn_now  = !btn_now;
        btn_left = btn_now ? $urandom_range(0, 120) : $urandom_range(0, 20);
      end else begin
        btn_left--;
      end
      // gray order 00, 01, 11, 10 as (a, b): a rises with b high going up
      a = (quad_idx == 2 || quad_idx == 3);
      b = (quad_idx == 1 || quad_idx == 2);
      send_word(OP_TICK, a, b, btn_now, 8'($urandom));
    end
  endtask

  // reset settings: edges, both directions, clamps, loads
  task automatic directed_items();
    send_word(OP_TICK, 0, 0, 1, 8'h00);  // A falls from its reset level
    send_word(OP_TICK, 1, 1, 1, 8'hFF);  // rising A with B high, fastest step up
    send_word(OP_TICK, 0, 1, 0, 8'h00);  // button low too early for a click
    send_word(OP_TICK, 1, 0, 0, 8'h00);  // rising A with B low, step down
    send_word(OP_TICK, 1, 0, 1, 8'h55);  // A held high, no step
    send_word(OP_LOAD, 1, 1, 1, 8'h00);  // load bottom, line bits ignored
    send_word(OP_TICK, 0, 0, 1, 8'hFF);
    send_word(OP_TICK, 1, 0, 1, 8'h00);  // step below zero clamps at the floor
    send_word(OP_LOAD, 0, 0, 0, 8'hFF);  // load top
    send_word(OP_TICK, 0, 1, 1, 8'hAA);
    send_word(OP_TICK, 1, 1, 1, 8'h00);  // step above 255 clamps at the ceiling
    send_word(OP_LOAD, 0, 1, 0, 8'h55);
    send_word(OP_LOAD, 1, 0, 1, 8'hAA);
    send_word(OP_TICK, 0, 1, 1, 8'h00);
    send_word(OP_TICK, 1, 1, 0, 8'h00);
    send_word(OP_TICK, 0, 0, 0, 8'h00);
    send_word(OP_TICK, 1, 0, 1, 8'h00);
    send_word(OP_LOAD, 0, 0, 1, 8'd127);
  endtask

  // both sides at full rate: back-to-back words with the sink always ready
  task automatic burst_run();
    settle();
    no_gaps = 1'b1;
    repeat (30) random_word();
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    in_tvalid   <= 1'b0;
    in_tuser    <= OP_TICK;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    repeat (100) random_word();
    for (int ph = 1; ph <= 8; ph++) begin
      // drain before touching registers
      settle();
      pick_settings(ph);
      send_quiet = ($urandom_range(0, 2) == 0);
      repeat (90) random_word();
    end
    send_quiet = 1'b0;
    burst_run();

    // drain, then allow for the output latency
    settle();
    repeat (5) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stalls in stretches, one long hold-off that fills the
  // output buffer and pushes back on the input
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int mode;
    int mode_left;
    int seen;
    bit held;
    bit rdy;
    stall_left = 0;
    hold_left  = 0;
    mode       = 0;
    mode_left  = 0;
    seen       = 0;
    held       = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        board.check_result(out_tdata);
        seen++;
      end
      if (!held && seen >= 250) begin
        held      = 1'b1;
        hold_left = 64;
      end
      // switch between gap-free and gappy stretches
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (no_gaps || mode == 0) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy        = 1'b1;
        stall_left = pick_gap(1'b0);
      end
      out_tready <= rdy;
    end
  end

  // watchdog: too long with no word, result or register write accepted
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) || !rst_n)
        idle = 0;
      else
        idle++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rotenc_pkg.sv
rtl/rotary_encoder_accel_position.sv
tb/sv/tb_rotary_encoder_accel_position.sv
